// ===== sv/sha256_stream_hasher_top_macros.svh =====
// Assertion macros for the SHA-256 stream hasher.
// Expects clk and arst_n in the scope of use; no other dependencies.
`ifndef SHA256_STREAM_HASHER_TOP_MACROS_SVH
`define SHA256_STREAM_HASHER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset
`define SHS_CHECK_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset
`define SHS_CHECK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/shs_pkg.sv =====
// Shared types, constants and SHA-256 tables for the stream hasher.
// No dependencies.
package shs_pkg;

	localparam logic [5:0] BIB_FULL      = 6'd63;
	localparam logic [5:0] BIB_LEN_START = 6'd56;
	localparam logic [5:0] ROUND_LAST    = 6'd63;
	localparam logic [1:0] WORD_LAST     = 2'd3;
	localparam logic [7:0] PAD_ONE_BYTE  = 8'h80;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT,
		ST_ROUND,
		ST_ADDH,
		ST_PAD_ONE,
		ST_PAD_ZERO,
		ST_PAD_LEN,
		ST_OUT
	} ctrl_state_t;

	typedef enum logic [1:0] {
		SRC_MSG,
		SRC_ONE,
		SRC_ZERO,
		SRC_LEN
	} byte_src_t;

	typedef struct packed {
		logic       shift_byte;
		byte_src_t  byte_src;
		logic       cnt_inc;
		logic       init_work;
		logic       round;
		logic [5:0] round_idx;
		logic       add_h;
		logic       restart;
		logic [1:0] word_idx;
	} shs_cmd_t;

	typedef struct packed {
		logic [5:0] bib;
	} shs_sts_t;

	// Initial hash values
	function automatic logic [31:0] init_h(input logic [2:0] idx);
		logic [31:0] v;
		case (idx)
			3'd0: v = 32'h6a09e667;
			3'd1: v = 32'hbb67ae85;
			3'd2: v = 32'h3c6ef372;
			3'd3: v = 32'ha54ff53a;
			3'd4: v = 32'h510e527f;
			3'd5: v = 32'h9b05688c;
			3'd6: v = 32'h1f83d9ab;
			default: v = 32'h5be0cd19;
		endcase
		return v;
	endfunction

	// Round constants
	function automatic logic [31:0] round_k(input logic [5:0] t);
		logic [31:0] v;
		case (t)
			6'd0:  v = 32'h428a2f98; 6'd1:  v = 32'h71374491;
			6'd2:  v = 32'hb5c0fbcf; 6'd3:  v = 32'he9b5dba5;
			6'd4:  v = 32'h3956c25b; 6'd5:  v = 32'h59f111f1;
			6'd6:  v = 32'h923f82a4; 6'd7:  v = 32'hab1c5ed5;
			6'd8:  v = 32'hd807aa98; 6'd9:  v = 32'h12835b01;
			6'd10: v = 32'h243185be; 6'd11: v = 32'h550c7dc3;
			6'd12: v = 32'h72be5d74; 6'd13: v = 32'h80deb1fe;
			6'd14: v = 32'h9bdc06a7; 6'd15: v = 32'hc19bf174;
			6'd16: v = 32'he49b69c1; 6'd17: v = 32'hefbe4786;
			6'd18: v = 32'h0fc19dc6; 6'd19: v = 32'h240ca1cc;
			6'd20: v = 32'h2de92c6f; 6'd21: v = 32'h4a7484aa;
			6'd22: v = 32'h5cb0a9dc; 6'd23: v = 32'h76f988da;
			6'd24: v = 32'h983e5152; 6'd25: v = 32'ha831c66d;
			6'd26: v = 32'hb00327c8; 6'd27: v = 32'hbf597fc7;
			6'd28: v = 32'hc6e00bf3; 6'd29: v = 32'hd5a79147;
			6'd30: v = 32'h06ca6351; 6'd31: v = 32'h14292967;
			6'd32: v = 32'h27b70a85; 6'd33: v = 32'h2e1b2138;
			6'd34: v = 32'h4d2c6dfc; 6'd35: v = 32'h53380d13;
			6'd36: v = 32'h650a7354; 6'd37: v = 32'h766a0abb;
			6'd38: v = 32'h81c2c92e; 6'd39: v = 32'h92722c85;
			6'd40: v = 32'ha2bfe8a1; 6'd41: v = 32'ha81a664b;
			6'd42: v = 32'hc24b8b70; 6'd43: v = 32'hc76c51a3;
			6'd44: v = 32'hd192e819; 6'd45: v = 32'hd6990624;
			6'd46: v = 32'hf40e3585; 6'd47: v = 32'h106aa070;
			6'd48: v = 32'h19a4c116; 6'd49: v = 32'h1e376c08;
			6'd50: v = 32'h2748774c; 6'd51: v = 32'h34b0bcb5;
			6'd52: v = 32'h391c0cb3; 6'd53: v = 32'h4ed8aa4a;
			6'd54: v = 32'h5b9cca4f; 6'd55: v = 32'h682e6ff3;
			6'd56: v = 32'h748f82ee; 6'd57: v = 32'h78a5636f;
			6'd58: v = 32'h84c87814; 6'd59: v = 32'h8cc70208;
			6'd60: v = 32'h90befffa; 6'd61: v = 32'ha4506ceb;
			6'd62: v = 32'hbef9a3f7;
			default: v = 32'hc67178f2;
		endcase
		return v;
	endfunction

endpackage

// ===== sv/shs_if.sv =====
// Stream channel interfaces for the hasher: byte input and digest output.
// No dependencies.
interface shs_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] msg_byte;
	logic       byte_present;
	logic       end_message;

	modport source (output valid, output msg_byte, output byte_present,
		output end_message, input ready);
	modport sink (input valid, input msg_byte, input byte_present,
		input end_message, output ready);
endinterface

interface shs_digest_if;
	logic        valid;
	logic        ready;
	logic [63:0] digest_word;
	logic [1:0]  word_index;
	logic        last_word;

	modport source (output valid, output digest_word, output word_index,
		output last_word, input ready);
	modport sink (input valid, input digest_word, input word_index,
		input last_word, output ready);
endinterface

// ===== sv/shs_ctrl.sv =====
// Controller FSM: byte intake, padding sequence, round count, digest readout.
// Depends on shs_pkg.
module shs_ctrl
	import shs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	output logic       byte_ready,
	input  logic       byte_present,
	input  logic       end_message,
	output logic       digest_valid,
	input  logic       digest_ready,
	output logic [1:0] word_index,
	output logic       last_word,
	output shs_cmd_t   cmd,
	input  shs_sts_t   sts
);

	ctrl_state_t state_q, state_d;
	ctrl_state_t ret_q, ret_d;
	logic [5:0]  t_q, t_d;
	logic [1:0]  word_q, word_d;
	logic        blk_full;

	assign blk_full   = (sts.bib == BIB_FULL);
	assign word_index = word_q;
	assign last_word  = (word_q == WORD_LAST);

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q   <= ST_IDLE;
			t_q     <= '0;
			word_q  <= '0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			t_q     <= t_d;
			word_q  <= word_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d      = state_q;
		ret_d        = ret_q;
		t_d          = t_q;
		word_d       = word_q;
		byte_ready   = 1'b0;
		digest_valid = 1'b0;
		cmd          = '0;
		cmd.byte_src = SRC_MSG;
		cmd.round_idx = t_q;
		cmd.word_idx = word_q;
		case (state_q)
			ST_IDLE: begin
				byte_ready = 1'b1;
				if (byte_valid) begin
					if (byte_present) begin
						cmd.shift_byte = 1'b1;
						cmd.cnt_inc    = 1'b1;
						if (blk_full) begin
							state_d = ST_INIT;
							ret_d   = end_message ? ST_PAD_ONE : ST_IDLE;
						end else if (end_message) begin
							state_d = ST_PAD_ONE;
						end
					end else if (end_message) begin
						state_d = ST_PAD_ONE;
					end
				end
			end
			ST_PAD_ONE: begin
				cmd.shift_byte = 1'b1;
				cmd.byte_src   = SRC_ONE;
				if (blk_full) begin
					state_d = ST_INIT;
					ret_d   = ST_PAD_ZERO;
				end else begin
					state_d = ST_PAD_ZERO;
				end
			end
			ST_PAD_ZERO: begin
				if (sts.bib == BIB_LEN_START) begin
					state_d = ST_PAD_LEN;
				end else begin
					cmd.shift_byte = 1'b1;
					cmd.byte_src   = SRC_ZERO;
					if (blk_full) begin
						state_d = ST_INIT;
						ret_d   = ST_PAD_ZERO;
					end
				end
			end
			ST_PAD_LEN: begin
				cmd.shift_byte = 1'b1;
				cmd.byte_src   = SRC_LEN;
				if (blk_full) begin
					state_d = ST_INIT;
					ret_d   = ST_OUT;
				end
			end
			ST_INIT: begin
				cmd.init_work = 1'b1;
				t_d     = '0;
				state_d = ST_ROUND;
			end
			ST_ROUND: begin
				cmd.round = 1'b1;
				t_d       = t_q + 6'd1;
				if (t_q == ROUND_LAST) begin
					state_d = ST_ADDH;
				end
			end
			ST_ADDH: begin
				cmd.add_h = 1'b1;
				state_d   = ret_q;
			end
			ST_OUT: begin
				digest_valid = 1'b1;
				if (digest_ready) begin
					word_d = word_q + 2'd1;
					if (word_q == WORD_LAST) begin
						cmd.restart = 1'b1;
						state_d     = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== sv/shs_datapath.sv =====
// Datapath: 512-bit block/schedule shift line, round unit, hash state, counters.
// Depends on shs_pkg.
module shs_datapath
	import shs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  shs_cmd_t    cmd,
	input  logic [7:0]  msg_byte,
	output shs_sts_t    sts,
	output logic [63:0] digest_word
);

	logic [511:0] blk_q;
	logic [31:0]  h_q [8];
	logic [31:0]  wv_q [8];
	logic [5:0]   bib_q;
	logic [60:0]  cnt_q;

	logic [63:0]  len_bits;
	logic [2:0]   len_sel;
	logic [7:0]   byte_val;
	logic [31:0]  w0, w1, w9, w14, g0, g1, wt;
	logic [31:0]  sig0, sig1, ch, maj, t1, t2;

	assign sts.bib  = bib_q;
	assign len_bits = {cnt_q, 3'b000};
	assign len_sel  = ~bib_q[2:0];

	// Byte to shift into the block
	always_comb begin
		case (cmd.byte_src)
			SRC_MSG:  byte_val = msg_byte;
			SRC_ONE:  byte_val = PAD_ONE_BYTE;
			SRC_LEN:  byte_val = len_bits[{len_sel, 3'b000} +: 8];
			default:  byte_val = 8'h00;
		endcase
	end

	// Schedule taps: word 0 is the oldest
	assign w0  = blk_q[511:480];
	assign w1  = blk_q[479:448];
	assign w9  = blk_q[223:192];
	assign w14 = blk_q[63:32];
	assign g0  = {w1[6:0], w1[31:7]} ^ {w1[17:0], w1[31:18]} ^ (w1 >> 3);
	assign g1  = {w14[16:0], w14[31:17]} ^ {w14[18:0], w14[31:19]} ^ (w14 >> 10);
	assign wt  = (cmd.round_idx[5:4] == 2'b00) ? w0 : (w0 + g0 + w9 + g1);

	// Round function
	assign sig1 = {wv_q[4][5:0], wv_q[4][31:6]} ^ {wv_q[4][10:0], wv_q[4][31:11]}
		^ {wv_q[4][24:0], wv_q[4][31:25]};
	assign ch   = (wv_q[4] & wv_q[5]) ^ (~wv_q[4] & wv_q[6]);
	assign t1   = wv_q[7] + sig1 + ch + round_k(cmd.round_idx) + wt;
	assign sig0 = {wv_q[0][1:0], wv_q[0][31:2]} ^ {wv_q[0][12:0], wv_q[0][31:13]}
		^ {wv_q[0][21:0], wv_q[0][31:22]};
	assign maj  = (wv_q[0] & wv_q[1]) ^ (wv_q[0] & wv_q[2]) ^ (wv_q[1] & wv_q[2]);
	assign t2   = sig0 + maj;

	assign digest_word = {h_q[{cmd.word_idx, 1'b0}], h_q[{cmd.word_idx, 1'b1}]};

	// Block shift line and working variables
	always_ff @(posedge clk) begin
		if (cmd.shift_byte) begin
			blk_q <= {blk_q[503:0], byte_val};
		end else if (cmd.round) begin
			blk_q <= {blk_q[479:0], wt};
		end
		if (cmd.init_work) begin
			for (int i = 0; i < 8; i++) begin
				wv_q[i] <= h_q[i];
			end
		end else if (cmd.round) begin
			wv_q[0] <= t1 + t2;
			wv_q[1] <= wv_q[0];
			wv_q[2] <= wv_q[1];
			wv_q[3] <= wv_q[2];
			wv_q[4] <= wv_q[3] + t1;
			wv_q[5] <= wv_q[4];
			wv_q[6] <= wv_q[5];
			wv_q[7] <= wv_q[6];
		end
	end

	// Hash state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= init_h(3'(i));
			end
			bib_q <= '0;
			cnt_q <= '0;
		end else begin
			if (cmd.restart) begin
				for (int i = 0; i < 8; i++) begin
					h_q[i] <= init_h(3'(i));
				end
				bib_q <= '0;
				cnt_q <= '0;
			end else begin
				if (cmd.add_h) begin
					for (int i = 0; i < 8; i++) begin
						h_q[i] <= h_q[i] + wv_q[i];
					end
				end
				if (cmd.shift_byte) begin
					bib_q <= bib_q + 6'd1;
				end
				if (cmd.cnt_inc) begin
					cnt_q <= cnt_q + 61'd1;
				end
			end
		end
	end

endmodule

// ===== sv/sha256_stream_hasher_top.sv =====
// Bytes are taken in idle; a filled block adds a compression (load, 64 rounds, add).
// End of message: padding shifts one byte per cycle, except while a full block compresses;
// one or two compressions, then four digest transfers. No bytes are taken during compression.
// Reset (arst_n, asynchronous): FSM idle, hash state to the initial values, counts to zero.
// Block buffer and working variables are not reset and need no clearing pass.
module sha256_stream_hasher_top
	import shs_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	shs_byte_if.sink     byte_ch,
	shs_digest_if.source digest_ch
);

`include "sha256_stream_hasher_top_macros.svh"

	shs_cmd_t cmd;
	shs_sts_t sts;

	shs_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_ch.valid),
		.byte_ready   (byte_ch.ready),
		.byte_present (byte_ch.byte_present),
		.end_message  (byte_ch.end_message),
		.digest_valid (digest_ch.valid),
		.digest_ready (digest_ch.ready),
		.word_index   (digest_ch.word_index),
		.last_word    (digest_ch.last_word),
		.cmd          (cmd),
		.sts          (sts)
	);

	shs_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.msg_byte    (byte_ch.msg_byte),
		.sts         (sts),
		.digest_word (digest_ch.digest_word)
	);

	// Checks
	`SHS_CHECK_NOW(a_no_intake_during_readout, digest_ch.valid, !byte_ch.ready, "byte intake during digest readout")
	`SHS_CHECK_NEXT(a_idle_after_last, digest_ch.valid && digest_ch.ready && digest_ch.last_word, byte_ch.ready && !digest_ch.valid, "not idle after last digest word")
	`SHS_CHECK_NEXT(a_word_sequence, digest_ch.valid && digest_ch.ready && !digest_ch.last_word, digest_ch.valid && (digest_ch.word_index == $past(digest_ch.word_index) + 2'd1), "digest word order broken")
	`SHS_CHECK_NOW(a_round_not_shift, cmd.round, !cmd.shift_byte && !cmd.restart, "round overlaps byte shift or restart")

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the SHA-256 stream hasher (sha256_stream_hasher_top).
// Depends on shs_pkg and the shs_byte_if / shs_digest_if interfaces from the RTL.
// A local SHA-256 predictor checks every digest word in order under random back-pressure.
module tb;
	import shs_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 300;
	localparam int MAX_REPORTS = 10;

	// SHA-256 round constants and initial chaining value
	localparam logic [31:0] ROUND_C [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};
	localparam logic [31:0] CHAIN_IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	// Message lengths that land on either side of the length-field boundary
	localparam int LONG_LEN [5] = '{55, 56, 62, 63, 64};

	typedef struct packed {
		logic [7:0] msg_byte;
		logic       byte_present;
		logic       end_message;
	} byte_item_t;

	typedef struct packed {
		logic [63:0] digest_word;
		logic [1:0]  word_index;
		logic        last_word;
	} digest_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	shs_byte_if   byte_ch ();
	shs_digest_if digest_ch ();

	sha256_stream_hasher_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_ch   (byte_ch),
		.digest_ch (digest_ch)
	);

	// Predictor state
	logic [31:0] chain [8] = CHAIN_IV;
	logic [7:0]  blk [64];
	logic [5:0]  blk_fill = '0;
	logic [60:0] msg_len = '0;

	byte_item_t   byte_q [$];
	digest_item_t digest_exp [$];
	byte_item_t   drv_item;
	digest_item_t exp_word;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int err_count = 0;
	int cycles = 0;

	function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
		return (v >> n) | (v << (32 - n));
	endfunction

	// One 64-round compression of blk into chain
	function automatic void compress_blk();
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] s0, s1, ch, mj, t1, t2;
		for (int t = 0; t < 64; t++) begin
			if (t < 16) begin
				w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
			end else begin
				s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
				s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
				w[t] = w[t-16] + s0 + w[t-7] + s1;
			end
		end
		v = chain;
		for (int t = 0; t < 64; t++) begin
			s1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
			ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
			t1 = v[7] + s1 + ch + ROUND_C[t] + w[t];
			s0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
			mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
			t2 = s0 + mj;
			v[7] = v[6];
			v[6] = v[5];
			v[5] = v[4];
			v[4] = v[3] + t1;
			v[3] = v[2];
			v[2] = v[1];
			v[1] = v[0];
			v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			chain[i] = chain[i] + v[i];
	endfunction

	// Absorb one accepted transfer; on end of message, pad and queue the digest
	function automatic void absorb_byte(input logic [7:0] b, input logic pres, input logic fin);
		logic [63:0]  bit_len;
		int           p;
		digest_item_t d;
		if (pres) begin
			blk[blk_fill] = b;
			msg_len = msg_len + 1'b1;
			blk_fill = blk_fill + 1'b1;
			if (blk_fill == 6'd0)
				compress_blk();
		end
		if (fin) begin
			bit_len = {msg_len, 3'b000};
			p = blk_fill;
			blk[p] = 8'h80;
			for (int i = p + 1; i < 64; i++)
				blk[i] = 8'h00;
			// no room for the length field: flush and pad a second block
			if (p >= 56) begin
				compress_blk();
				for (int i = 0; i < 64; i++)
					blk[i] = 8'h00;
			end
			for (int i = 0; i < 8; i++)
				blk[56+i] = bit_len[63-8*i -: 8];
			compress_blk();
			for (int k = 0; k < 4; k++) begin
				d.digest_word = {chain[2*k], chain[2*k+1]};
				d.word_index = 2'(k);
				d.last_word = (2'(k) == WORD_LAST);
				digest_exp.push_back(d);
			end
			chain = CHAIN_IV;
			blk_fill = '0;
			msg_len = '0;
		end
	endfunction

	task automatic push_item(input logic [7:0] b, input logic pres, input logic fin);
		byte_item_t it;
		it.msg_byte = b;
		it.byte_present = pres;
		it.end_message = fin;
		byte_q.push_back(it);
	endtask

	// Random message of len bytes, with stray non-byte transfers mixed in;
	// the end flag rides on the last byte or comes as a separate transfer
	task automatic push_msg(input int len);
		bit split;
		split = (len == 0) || ($urandom_range(0, 1) == 1);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 7) == 0)
				push_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
			push_item(8'($urandom_range(0, 255)), 1'b1, (i == len - 1) && !split);
		end
		if (split)
			push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
	endtask

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Byte channel driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_ch.valid <= 1'b0;
			byte_ch.msg_byte <= 8'h00;
			byte_ch.byte_present <= 1'b0;
			byte_ch.end_message <= 1'b0;
		end else begin
			if (byte_ch.valid && byte_ch.ready)
				absorb_byte(byte_ch.msg_byte, byte_ch.byte_present, byte_ch.end_message);
			if (!byte_ch.valid || byte_ch.ready) begin
				if (byte_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					drv_item = byte_q.pop_front();
					byte_ch.valid <= 1'b1;
					byte_ch.msg_byte <= drv_item.msg_byte;
					byte_ch.byte_present <= drv_item.byte_present;
					byte_ch.end_message <= drv_item.end_message;
				end else begin
					byte_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Digest channel monitor and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digest_ch.ready <= 1'b0;
		end else begin
			if (digest_ch.valid && digest_ch.ready) begin
				if (digest_exp.size() == 0) begin
					if (err_count < MAX_REPORTS)
						$display("unexpected digest transfer: word %h idx %0d last %b",
							digest_ch.digest_word, digest_ch.word_index, digest_ch.last_word);
					err_count++;
				end else begin
					exp_word = digest_exp.pop_front();
					if (digest_ch.digest_word !== exp_word.digest_word ||
						digest_ch.word_index !== exp_word.word_index ||
						digest_ch.last_word !== exp_word.last_word) begin
						if (err_count < MAX_REPORTS)
							$display("digest mismatch: exp %h/%0d/%b got %h/%0d/%b",
								exp_word.digest_word, exp_word.word_index, exp_word.last_word,
								digest_ch.digest_word, digest_ch.word_index,
								digest_ch.last_word);
						err_count++;
					end
				end
			end
			digest_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
				default: begin send_idle_pct = 27; recv_stall_pct = 27; end
			endcase

			if (ph == 0) begin
				// empty message, twice to check the restart
				push_item(8'h00, 1'b0, 1'b1);
				push_item(8'hff, 1'b0, 1'b1);
				// single bytes at both extremes, byte and end together
				push_item(8'h00, 1'b1, 1'b1);
				push_item(8'hff, 1'b1, 1'b1);
				// "abc"
				push_item(8'h61, 1'b1, 1'b0);
				push_item(8'h62, 1'b1, 1'b0);
				push_item(8'h63, 1'b1, 1'b1);
				// stray non-byte transfers inside a message, then a bare end
				push_item(8'hff, 1'b0, 1'b0);
				push_item(8'h5a, 1'b1, 1'b0);
				push_item(8'ha5, 1'b0, 1'b0);
				push_item(8'hff, 1'b1, 1'b0);
				push_item(8'h00, 1'b0, 1'b1);
			end

			// one long message near the length-field boundary
			if (ph == 3)
				push_msg(LONG_LEN[$urandom_range(0, 4)]);
			for (int m = 0; m < 2; m++)
				push_msg($urandom_range(0, 8));

			while (byte_q.size() != 0 || byte_ch.valid)
				@(negedge clk);
		end

		while (digest_exp.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (err_count == 0 && digest_exp.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
